// File: hdl/segx_pkg.sv
// Shared constants, widths and types of the segment intersection pipeline.
package segx_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_BITS = 32;
  localparam int DIFF_W     = COORD_BITS + 1;      // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;          // product of two differences
  localparam int DEN_W      = PROD_W + 1;          // determinant, cross product
  localparam int CP_W       = 2 * COORD_BITS + 1;  // c1, c2
  localparam int NUM_W      = 3 * COORD_BITS + 3;  // numerators
  localparam int QUO_W      = COORD_BITS;          // quotient magnitude
  localparam int BND_W      = COORD_BITS + 2;      // widened box bounds
  localparam int CTOL_W     = 16;
  localparam int ATOL_W     = 32;
  localparam int CFG_W      = 32;
  localparam int DIV_STAGES = QUO_W;

  // Register indexes
  localparam logic REG_COORD_TOL = 1'b0;
  localparam logic REG_AREA_TOL  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_PAR  = 2'd1;
  localparam logic [1:0] ST_COL  = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  // Side information that travels with a word through the pipeline
  typedef struct packed {
    logic signed [BND_W-1:0] ax_lo;
    logic signed [BND_W-1:0] ax_hi;
    logic signed [BND_W-1:0] ay_lo;
    logic signed [BND_W-1:0] ay_hi;
    logic signed [BND_W-1:0] bx_lo;
    logic signed [BND_W-1:0] bx_hi;
    logic signed [BND_W-1:0] by_lo;
    logic signed [BND_W-1:0] by_hi;
    logic                    whole;
    logic                    flat;
    logic                    colin;
    logic                    neg_x;
    logic                    neg_y;
    logic                    ovf_x;
    logic                    ovf_y;
  } side_t;

endpackage

// File: hdl/segx_in_if.sv
// Input channel: one pair of segments per word.
interface segx_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [segx_pkg::COORD_BITS-1:0] a_start_x;
  logic signed [segx_pkg::COORD_BITS-1:0] a_start_y;
  logic signed [segx_pkg::COORD_BITS-1:0] a_end_x;
  logic signed [segx_pkg::COORD_BITS-1:0] a_end_y;
  logic signed [segx_pkg::COORD_BITS-1:0] b_start_x;
  logic signed [segx_pkg::COORD_BITS-1:0] b_start_y;
  logic signed [segx_pkg::COORD_BITS-1:0] b_end_x;
  logic signed [segx_pkg::COORD_BITS-1:0] b_end_y;
  logic                          whole_lines;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, whole_lines,
                  input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, whole_lines,
                output ready);
endinterface

// File: hdl/segx_out_if.sv
// Output channel: one intersection result per word.
interface segx_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [segx_pkg::COORD_BITS-1:0] cross_x;
  logic signed [segx_pkg::COORD_BITS-1:0] cross_y;
  logic [1:0]                             status;
  logic                                   clipped;

  modport source (output valid, cross_x, cross_y, status, clipped, input ready);
  modport sink (input valid, cross_x, cross_y, status, clipped, output ready);
endinterface

// File: hdl/segment_intersection.sv
// Segment intersection: fully pipelined 2-D line/segment intersection unit.
//
// Channels: "pair" takes a word holding two segments (Q16.16 endpoints) and
// the whole_lines flag; "result" returns one word per pair, in order, with
// the intersection point, a status code and a clipped flag.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 coord tolerance, 1 area tolerance); write only while the block is empty.
// Throughput: one pair per cycle while result.ready does not hold the
// pipeline. The depth is set by the restoring divider, 32 stages with one
// quotient bit each, behind 7 stages of differences, products, numerators and
// magnitudes, plus the output register.
// Reset (rst, synchronous) empties the pipeline and sets the tolerances to
// 0 and 4.
// Stall: when a result waits and result.ready is low, the whole pipeline
// holds and pair.ready drops; nothing is lost or repeated.
module segment_intersection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [segx_pkg::CFG_W-1:0]    cfg_data,
  segx_in_if.sink                       pair,
  segx_out_if.source                    result
);
  import segx_pkg::*;

  // Configuration registers
  logic [CTOL_W-1:0] coord_tol;
  logic [ATOL_W-1:0] area_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_tol <= '0;
      area_tol  <= ATOL_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COORD_TOL: coord_tol <= cfg_data[CTOL_W-1:0];
        REG_AREA_TOL:  area_tol  <= cfg_data[ATOL_W-1:0];
        default:       ;
      endcase
    end
  end

  // Global advance: the pipeline moves when the output register is free
  logic advance;
  logic vo;
  assign advance    = !vo || result.ready;
  assign pair.ready = advance;

  // Stage 1: differences
  logic v1;
  logic signed [COORD_BITS-1:0] s1_x1, s1_y1, s1_x2, s1_y2, s1_x3, s1_y3, s1_x4, s1_y4;
  logic signed [DIFF_W-1:0] s1_dx12, s1_dy12, s1_dx34, s1_dy34, s1_ey31, s1_ex31;
  logic s1_whole;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (advance) v1 <= pair.valid;
    if (advance) begin
      s1_x1 <= pair.a_start_x;
      s1_y1 <= pair.a_start_y;
      s1_x2 <= pair.a_end_x;
      s1_y2 <= pair.a_end_y;
      s1_x3 <= pair.b_start_x;
      s1_y3 <= pair.b_start_y;
      s1_x4 <= pair.b_end_x;
      s1_y4 <= pair.b_end_y;
      s1_dx12 <= DIFF_W'(pair.a_start_x) - DIFF_W'(pair.a_end_x);
      s1_dy12 <= DIFF_W'(pair.a_start_y) - DIFF_W'(pair.a_end_y);
      s1_dx34 <= DIFF_W'(pair.b_start_x) - DIFF_W'(pair.b_end_x);
      s1_dy34 <= DIFF_W'(pair.b_start_y) - DIFF_W'(pair.b_end_y);
      s1_ey31 <= DIFF_W'(pair.b_start_y) - DIFF_W'(pair.a_start_y);
      s1_ex31 <= DIFF_W'(pair.b_start_x) - DIFF_W'(pair.a_start_x);
      s1_whole <= pair.whole_lines;
    end
  end

  // Stage 2: products and widened boxes
  logic v2;
  logic signed [PROD_W-1:0] s2_pd1, s2_pd2, s2_pc1, s2_pc2;
  logic signed [2*COORD_BITS-1:0] s2_pa, s2_pb, s2_pe, s2_pf;
  logic signed [DIFF_W-1:0] s2_dx12, s2_dy12, s2_dx34, s2_dy34;
  side_t s2_side;
  side_t s2_side_next;
  logic signed [BND_W-1:0] tol_b;

  assign tol_b = BND_W'($signed({1'b0, coord_tol}));

  function automatic logic signed [BND_W-1:0] lo_of(logic signed [COORD_BITS-1:0] a,
                                                    logic signed [COORD_BITS-1:0] b,
                                                    logic signed [BND_W-1:0] t);
    return (a < b) ? BND_W'(a) - t : BND_W'(b) - t;
  endfunction

  function automatic logic signed [BND_W-1:0] hi_of(logic signed [COORD_BITS-1:0] a,
                                                    logic signed [COORD_BITS-1:0] b,
                                                    logic signed [BND_W-1:0] t);
    return (a < b) ? BND_W'(b) + t : BND_W'(a) + t;
  endfunction

  // widened bounding boxes of both segments
  always_comb begin
    s2_side_next       = '0;
    s2_side_next.ax_lo = lo_of(s1_x1, s1_x2, tol_b);
    s2_side_next.ax_hi = hi_of(s1_x1, s1_x2, tol_b);
    s2_side_next.ay_lo = lo_of(s1_y1, s1_y2, tol_b);
    s2_side_next.ay_hi = hi_of(s1_y1, s1_y2, tol_b);
    s2_side_next.bx_lo = lo_of(s1_x3, s1_x4, tol_b);
    s2_side_next.bx_hi = hi_of(s1_x3, s1_x4, tol_b);
    s2_side_next.by_lo = lo_of(s1_y3, s1_y4, tol_b);
    s2_side_next.by_hi = hi_of(s1_y3, s1_y4, tol_b);
    s2_side_next.whole = s1_whole;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (advance) v2 <= v1;
    if (advance) begin
      s2_pd1 <= s1_dx12 * s1_dy34;
      s2_pd2 <= s1_dy12 * s1_dx34;
      s2_pc1 <= s1_dx12 * s1_ey31;
      s2_pc2 <= s1_dy12 * s1_ex31;
      s2_pa  <= s1_x1 * s1_y2;
      s2_pb  <= s1_y1 * s1_x2;
      s2_pe  <= s1_x3 * s1_y4;
      s2_pf  <= s1_y3 * s1_x4;
      s2_dx12 <= s1_dx12;
      s2_dy12 <= s1_dy12;
      s2_dx34 <= s1_dx34;
      s2_dy34 <= s1_dy34;
      s2_side <= s2_side_next;
    end
  end

  // Stage 3: determinant, cross product, c1 and c2
  logic v3;
  logic signed [DEN_W-1:0] s3_den, s3_cr;
  logic signed [CP_W-1:0] s3_c1, s3_c2;
  logic signed [DIFF_W-1:0] s3_dx12, s3_dy12, s3_dx34, s3_dy34;
  side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (advance) v3 <= v2;
    if (advance) begin
      s3_den  <= DEN_W'(s2_pd1) - DEN_W'(s2_pd2);
      s3_cr   <= DEN_W'(s2_pc1) - DEN_W'(s2_pc2);
      s3_c1   <= CP_W'(s2_pa) - CP_W'(s2_pb);
      s3_c2   <= CP_W'(s2_pe) - CP_W'(s2_pf);
      s3_dx12 <= s2_dx12;
      s3_dy12 <= s2_dy12;
      s3_dx34 <= s2_dx34;
      s3_dy34 <= s2_dy34;
      s3_side <= s2_side;
    end
  end

  // Stage 4: numerator partial products (c split at bit 32), tolerance tests
  logic v4;
  logic signed [PROD_W-1:0] s4_xa, s4_xb, s4_xc, s4_xd, s4_ya, s4_yb, s4_yc, s4_yd;
  logic signed [DEN_W-1:0] s4_den;
  side_t s4_side;
  side_t s4_side_next;
  logic signed [DIFF_W-1:0] c1_hi, c2_hi, c1_lo, c2_lo;

  assign c1_hi = s3_c1[CP_W-1:COORD_BITS];
  assign c2_hi = s3_c2[CP_W-1:COORD_BITS];
  assign c1_lo = $signed({1'b0, s3_c1[COORD_BITS-1:0]});
  assign c2_lo = $signed({1'b0, s3_c2[COORD_BITS-1:0]});

  function automatic logic below_tol(logic signed [DEN_W-1:0] v, logic [ATOL_W-1:0] t);
    logic [DEN_W-1:0] mag;
    mag = v[DEN_W-1] ? DEN_W'(-v) : DEN_W'(v);
    return (v == '0) || (mag < DEN_W'(t));
  endfunction

  // parallel and collinear flags join the side word
  always_comb begin
    s4_side_next       = s3_side;
    s4_side_next.flat  = below_tol(s3_den, area_tol);
    s4_side_next.colin = below_tol(s3_cr, area_tol);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (advance) v4 <= v3;
    if (advance) begin
      s4_xa <= c1_hi * s3_dx34;
      s4_xb <= c1_lo * s3_dx34;
      s4_xc <= c2_hi * s3_dx12;
      s4_xd <= c2_lo * s3_dx12;
      s4_ya <= c1_hi * s3_dy34;
      s4_yb <= c1_lo * s3_dy34;
      s4_yc <= c2_hi * s3_dy12;
      s4_yd <= c2_lo * s3_dy12;
      s4_den <= s3_den;
      s4_side <= s4_side_next;
    end
  end

  // Stage 5: numerators
  logic v5;
  logic signed [NUM_W-1:0] s5_nx, s5_ny;
  logic signed [DEN_W-1:0] s5_den;
  side_t s5_side;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (advance) v5 <= v4;
    if (advance) begin
      s5_nx <= ((NUM_W'(s4_xa) - NUM_W'(s4_xc)) <<< COORD_BITS)
               + NUM_W'(s4_xb) - NUM_W'(s4_xd);
      s5_ny <= ((NUM_W'(s4_ya) - NUM_W'(s4_yc)) <<< COORD_BITS)
               + NUM_W'(s4_yb) - NUM_W'(s4_yd);
      s5_den  <= s4_den;
      s5_side <= s4_side;
    end
  end

  // Stage 6: magnitudes and quotient signs
  logic v6;
  logic [NUM_W-1:0] s6_ax, s6_ay;
  logic [DEN_W-1:0] s6_ad;
  side_t s6_side;
  side_t s6_side_next;

  always_comb begin
    s6_side_next       = s5_side;
    s6_side_next.neg_x = s5_nx[NUM_W-1] ^ s5_den[DEN_W-1];
    s6_side_next.neg_y = s5_ny[NUM_W-1] ^ s5_den[DEN_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (advance) v6 <= v5;
    if (advance) begin
      s6_ax <= s5_nx[NUM_W-1] ? NUM_W'(-s5_nx) : NUM_W'(s5_nx);
      s6_ay <= s5_ny[NUM_W-1] ? NUM_W'(-s5_ny) : NUM_W'(s5_ny);
      s6_ad <= s5_den[DEN_W-1] ? DEN_W'(-s5_den) : DEN_W'(s5_den);
      s6_side <= s6_side_next;
    end
  end

  // Divider: entry stage flags quotients of 2^32 or more, then one bit a stage
  logic                 vd    [0:DIV_STAGES];
  logic [NUM_W-1:0]     rem_x [0:DIV_STAGES];
  logic [NUM_W-1:0]     rem_y [0:DIV_STAGES];
  logic [QUO_W-1:0]     quo_x [0:DIV_STAGES];
  logic [QUO_W-1:0]     quo_y [0:DIV_STAGES];
  logic [DEN_W-1:0]     dv    [0:DIV_STAGES];
  side_t                dside [0:DIV_STAGES];
  side_t                dside0_next;
  logic [NUM_W-1:0]     rem_x_next [0:DIV_STAGES-1];
  logic [NUM_W-1:0]     rem_y_next [0:DIV_STAGES-1];
  logic [QUO_W-1:0]     quo_x_next [0:DIV_STAGES-1];
  logic [QUO_W-1:0]     quo_y_next [0:DIV_STAGES-1];
  logic [NUM_W-1:0]     dshift     [0:DIV_STAGES-1];

  // overflow flags of the quotients
  always_comb begin
    dside0_next       = s6_side;
    dside0_next.ovf_x = s6_ax >= {s6_ad, {QUO_W{1'b0}}};
    dside0_next.ovf_y = s6_ay >= {s6_ad, {QUO_W{1'b0}}};
  end

  // Compare and subtract of the shifted divisor, one per stage
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      dshift[k]     = NUM_W'(dv[k]) << (DIV_STAGES - 1 - k);
      rem_x_next[k] = rem_x[k];
      rem_y_next[k] = rem_y[k];
      quo_x_next[k] = quo_x[k];
      quo_y_next[k] = quo_y[k];
      if (rem_x[k] >= dshift[k]) begin
        rem_x_next[k] = rem_x[k] - dshift[k];
        quo_x_next[k][DIV_STAGES-1-k] = 1'b1;
      end
      if (rem_y[k] >= dshift[k]) begin
        rem_y_next[k] = rem_y[k] - dshift[k];
        quo_y_next[k][DIV_STAGES-1-k] = 1'b1;
      end
    end
  end

  // Divider registers: entry stage and the quotient bit stages
  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (advance) vd[0] <= v6;
    if (advance) begin
      rem_x[0] <= s6_ax;
      rem_y[0] <= s6_ay;
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      dv[0]    <= s6_ad;
      dside[0] <= dside0_next;
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rst) vd[k+1] <= 1'b0;
      else if (advance) vd[k+1] <= vd[k];
      if (advance) begin
        rem_x[k+1] <= rem_x_next[k];
        rem_y[k+1] <= rem_y_next[k];
        quo_x[k+1] <= quo_x_next[k];
        quo_y[k+1] <= quo_y_next[k];
        dv[k+1]    <= dv[k];
        dside[k+1] <= dside[k];
      end
    end
  end

  // Final stage: saturation, sign, box test and status
  side_t fs;
  logic sat_x, sat_y, in_boxes;
  logic [QUO_W-1:0] mag_x, mag_y;
  logic signed [COORD_BITS-1:0] px, py;
  logic signed [BND_W-1:0] pxb, pyb;
  logic [1:0] st_next;
  localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};

  assign fs = dside[DIV_STAGES];

  always_comb begin
    sat_x = fs.ovf_x || (quo_x[DIV_STAGES] > (fs.neg_x ? NEG_LIM : POS_LIM));
    sat_y = fs.ovf_y || (quo_y[DIV_STAGES] > (fs.neg_y ? NEG_LIM : POS_LIM));
    mag_x = sat_x ? (fs.neg_x ? NEG_LIM : POS_LIM) : quo_x[DIV_STAGES];
    mag_y = sat_y ? (fs.neg_y ? NEG_LIM : POS_LIM) : quo_y[DIV_STAGES];
    px = fs.neg_x ? $signed(-mag_x) : $signed(mag_x);
    py = fs.neg_y ? $signed(-mag_y) : $signed(mag_y);
    pxb = BND_W'(px);
    pyb = BND_W'(py);
    in_boxes = (pxb >= fs.ax_lo) && (pxb <= fs.ax_hi) &&
               (pyb >= fs.ay_lo) && (pyb <= fs.ay_hi) &&
               (pxb >= fs.bx_lo) && (pxb <= fs.bx_hi) &&
               (pyb >= fs.by_lo) && (pyb <= fs.by_hi);
    priority if (fs.flat) begin
      st_next = (!fs.whole && fs.colin) ? ST_COL : ST_PAR;
    end else if (!fs.whole && !in_boxes) begin
      st_next = ST_NONE;
    end else begin
      st_next = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (advance) vo <= vd[DIV_STAGES];
    if (advance) begin
      result.cross_x <= fs.flat ? '0 : px;
      result.cross_y <= fs.flat ? '0 : py;
      result.clipped <= !fs.flat && (sat_x || sat_y);
      result.status  <= st_next;
    end
  end

  assign result.valid = vo;

`ifndef ASSERT_OFF
  // A parallel or collinear result carries no point
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_PAR || result.status == ST_COL)
    |-> result.cross_x == '0 && result.cross_y == '0 && !result.clipped)
    else $error("flat result with nonzero point");

  // An accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pair.valid && pair.ready |=> v1)
    else $error("accepted word lost at entry");

  // A stalled result is not replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.status)
      && $stable(result.cross_x) && $stable(result.cross_y))
    else $error("stalled result changed");

  // The pipeline is empty right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result.valid && !v1 && !vd[0])
    else $error("pipeline not empty after reset");
`endif

endmodule

// File: tb/tb_ifs.sv
`timescale 1ns / 1ps
// Testbench copies of nothing: channel interfaces are taken from the RTL.
package tb_segx_types;
  typedef struct {
    logic signed [31:0] c [8];
    logic               whole;
  } seg_pair_t;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [1:0]         status;
    logic               clipped;
  } seg_res_t;
endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench of the segment intersection unit with predictor and checker.
module tb_top;
  import segx_pkg::*;
  import tb_segx_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_COORD_TOL;
  logic [CFG_W-1:0] cfg_data = '0;

  segx_in_if  pair_if ();
  segx_out_if res_if ();

  segment_intersection u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pair(pair_if.sink), .result(res_if.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tolerances as the predictor sees them
  logic [15:0] coord_tol = 16'd0;
  logic [31:0] area_tol  = 32'd4;

  seg_pair_t pending_pairs [$];
  seg_res_t  expected_results [$];
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  errors = 0, n_checked = 0, n_sent = 0;
  int  cnt_status [4] = '{0, 0, 0, 0};
  int  n_clipped = 0;
  longint cycles = 0;

  // handshake seen at the rising edge
  bit pair_if_taken = 1'b0;

  // below the area tolerance, exact zero always counts
  function automatic bit is_flat(logic signed [127:0] v);
    logic [127:0] m;
    m = v < 0 ? -v : v;
    return (v == 0) || (m < {96'd0, area_tol});
  endfunction

  // truncated quotient saturated to 32-bit signed
  function automatic logic signed [63:0] div_sat(logic signed [127:0] n,
                                                 logic signed [127:0] d,
                                                 ref bit sat);
    logic [127:0] q, lim;
    bit neg;
    neg = (n < 0) != (d < 0);
    q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic bit in_span(logic signed [63:0] p, logic signed [63:0] a,
                                 logic signed [63:0] b);
    logic signed [63:0] lo, hi, t;
    t = {48'd0, coord_tol};
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    return p >= lo - t && p <= hi + t;
  endfunction

  function automatic seg_res_t predict_crossing(seg_pair_t p);
    seg_res_t r;
    logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [127:0] den, crs, c1, c2, nx, ny;
    logic signed [63:0] px, py;
    bit sat;
    x1 = p.c[0]; y1 = p.c[1]; x2 = p.c[2]; y2 = p.c[3];
    x3 = p.c[4]; y3 = p.c[5]; x4 = p.c[6]; y4 = p.c[7];
    sat = 1'b0;
    px = 0;
    py = 0;
    den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    if (is_flat(den)) begin
      crs = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
      r.status = (!p.whole && is_flat(crs)) ? ST_COL : ST_PAR;
    end else begin
      c1 = x1 * y2 - y1 * x2;
      c2 = x3 * y4 - y3 * x4;
      nx = c1 * (x3 - x4) - (x1 - x2) * c2;
      ny = c1 * (y3 - y4) - (y1 - y2) * c2;
      px = div_sat(nx, den, sat);
      py = div_sat(ny, den, sat);
      r.status = ST_OK;
      if (!p.whole && !(in_span(px, x1, x2) && in_span(py, y1, y2) &&
                        in_span(px, x3, x4) && in_span(py, y3, y4)))
        r.status = ST_NONE;
    end
    r.x = px[31:0];
    r.y = py[31:0];
    r.clipped = sat;
    return r;
  endfunction

  // driver: next word presented at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      pair_if.valid <= 1'b0;
    end else begin
      if (!pair_if.valid || pair_if_taken) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          seg_pair_t p;
          p = pending_pairs.pop_front();
          expected_results.push_back(predict_crossing(p));
          n_sent++;
          pair_if.valid       <= 1'b1;
          pair_if.a_start_x   <= p.c[0];
          pair_if.a_start_y   <= p.c[1];
          pair_if.a_end_x     <= p.c[2];
          pair_if.a_end_y     <= p.c[3];
          pair_if.b_start_x   <= p.c[4];
          pair_if.b_start_y   <= p.c[5];
          pair_if.b_end_x     <= p.c[6];
          pair_if.b_end_y     <= p.c[7];
          pair_if.whole_lines <= p.whole;
        end else begin
          pair_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) pair_if_taken <= pair_if.valid && pair_if.ready && !rst;

  always @(negedge clk)
    res_if.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);

  // monitor and checker
  always @(posedge clk) begin
    cycles++;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h st=%0d", $time,
                 res_if.cross_x, res_if.cross_y, res_if.status);
        errors++;
      end else begin
        seg_res_t e;
        e = expected_results.pop_front();
        n_checked++;
        cnt_status[e.status]++;
        if (e.clipped) n_clipped++;
        if (res_if.cross_x !== e.x || res_if.cross_y !== e.y ||
            res_if.status !== e.status || res_if.clipped !== e.clipped) begin
          $display("%0t: mismatch exp x=%h y=%h st=%0d clip=%0b act x=%h y=%h st=%0d clip=%0b",
                   $time, e.x, e.y, e.status, e.clipped, res_if.cross_x,
                   res_if.cross_y, res_if.status, res_if.clipped);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(255)) - 128;
      2: return ($signed($urandom_range(2047)) - 1024) <<< 16;
      3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF;
    endcase
  endfunction

  // random pair: crossings, parallels, collinears and noise
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    logic signed [31:0] dx, dy;
    int k;
    for (int i = 0; i < 8; i++) p.c[i] = rand_coord();
    p.whole = $urandom_range(3) == 0;
    case ($urandom_range(9))
      0, 1: begin
        dx = p.c[2] - p.c[0];
        dy = p.c[3] - p.c[1];
        k = $urandom_range(1) ? 1 : -1;
        p.c[6] = p.c[4] + k * dx;
        p.c[7] = p.c[5] + k * dy;
      end
      2: begin
        dx = $signed($urandom_range(64)) - 32;
        dy = $signed($urandom_range(64)) - 32;
        p.c[2] = p.c[0] + dx * 3;
        p.c[3] = p.c[1] + dy * 3;
        p.c[4] = p.c[0] + dx;
        p.c[5] = p.c[1] + dy;
        p.c[6] = p.c[0] + dx * 5;
        p.c[7] = p.c[1] + dy * 5;
      end
      3, 4, 5: begin
        // crossing near the origin with small segments
        p.c[0] = -($urandom_range(9999) << 4); p.c[2] = $urandom_range(9999) << 4;
        p.c[1] = $signed($urandom_range(99999)) - 50000;
        p.c[3] = $signed($urandom_range(99999)) - 50000;
        p.c[5] = -($urandom_range(9999) << 4); p.c[7] = $urandom_range(9999) << 4;
        p.c[4] = $signed($urandom_range(99999)) - 50000;
        p.c[6] = $signed($urandom_range(99999)) - 50000;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pair(input logic signed [31:0] a0, a1, a2, a3, b0, b1, b2, b3,
                          input logic w);
    seg_pair_t p;
    p.c = '{a0, a1, a2, a3, b0, b1, b2, b3};
    p.whole = w;
    pending_pairs.push_back(p);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COORD_TOL) coord_tol = val[15:0];
    else area_tol = val;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    localparam logic signed [31:0] MX = 32'sh7FFF_FFFF, MN = 32'sh8000_0000;
    pair_if.valid = 1'b0;
    {pair_if.a_start_x, pair_if.a_start_y, pair_if.a_end_x, pair_if.a_end_y} = '0;
    {pair_if.b_start_x, pair_if.b_start_y, pair_if.b_end_x, pair_if.b_end_y} = '0;
    pair_if.whole_lines = 1'b0;
    res_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: crossing, miss, parallel, collinear, zero length, extremes
    send_idle_pct = 37; recv_idle_pct = 53;
    add_pair(-65536, 0, 65536, 0, 0, -65536, 0, 65536, 1'b0);
    add_pair(-65536, 0, 65536, 0, 0, -65536, 0, 65536, 1'b1);
    add_pair(0, 0, 65536, 0, 131072, -65536, 131072, 65536, 1'b0);
    add_pair(0, 0, 65536, 0, 131072, -65536, 131072, 65536, 1'b1);
    add_pair(0, 0, 65536, 65536, 0, 65536, 65536, 131072, 1'b0);
    add_pair(0, 0, 65536, 65536, 0, 65536, 65536, 131072, 1'b1);
    add_pair(0, 0, 65536, 65536, 131072, 131072, 196608, 196608, 1'b0);
    add_pair(0, 0, 65536, 65536, 131072, 131072, 196608, 196608, 1'b1);
    add_pair(5, 5, 5, 5, 5, 5, 5, 5, 1'b0);
    add_pair(0, 0, 1, 0, 0, 0, 0, 1, 1'b0);
    add_pair(0, 0, 2, 1, 0, 1, 2, 0, 1'b0);
    add_pair(MN, MN, MX, MX, MN, MX, MX, MN, 1'b0);
    add_pair(MX, MN, MN, MX, MX, MX, MN, MN, 1'b1);
    add_pair(0, 0, 1, 1, 1, 0, 0, 2, 1'b1);
    add_pair(MN, 0, MN, 1, MX, 0, MN, 2, 1'b1);
    add_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
    add_pair(0, 0, 65536, 1, 0, 65536, 65536, 65537, 1'b0);
    add_pair(0, 0, 3, 1, 0, 1, 3, 0, 1'b0);
    drain();

    // tolerance extremes, then mid settings
    write_reg(REG_COORD_TOL, 32'hFFFF);
    write_reg(REG_AREA_TOL, 32'd0);
    add_pair(0, 0, 65536, 0, 131072, -65536, 131072, 65536, 1'b0);
    add_pair(0, 0, 65536, 0, 65536 + 100, -65536, 65536 + 100, 65536, 1'b0);
    add_pair(0, 0, 65536, 65536, 0, 65536, 65536, 131072, 1'b0);
    add_pair(0, 0, 3, 1, 0, 1, 3, 0, 1'b0);
    for (int i = 0; i < 330; i++) pending_pairs.push_back(rand_pair());
    drain();

    send_idle_pct = 53; recv_idle_pct = 37;
    write_reg(REG_AREA_TOL, 32'hFFFF_FFFF);
    write_reg(REG_COORD_TOL, 32'd0);
    for (int i = 0; i < 340; i++) pending_pairs.push_back(rand_pair());
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_AREA_TOL, $urandom_range(1000));
    write_reg(REG_COORD_TOL, $urandom_range(300));
    for (int i = 0; i < 360; i++) pending_pairs.push_back(rand_pair());
    drain();

    $display("%0d pairs checked: ok %0d, parallel %0d, collinear %0d, miss %0d",
             n_checked, cnt_status[0], cnt_status[1], cnt_status[2], cnt_status[3]);
    $display("%0d saturated points, four tolerance settings", n_clipped);
    if (errors == 0 && expected_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
